### rtl/kvs_pkg.sv
// ----------------------------------------------------------------------------
// kvs_pkg: shared types and constants for the keyframe vector sampler
// Holds the table geometry, the value and fraction widths, the command codes
// and the xyz vector type.
// ----------------------------------------------------------------------------
package kvs_pkg;

	localparam int MAX_KEYS   = 256;
	localparam int KEY_BITS   = $clog2(MAX_KEYS);
	localparam int COUNT_BITS = KEY_BITS + 1;
	localparam int TIME_BITS  = 16;
	localparam int VALUE_BITS = 32;
	localparam int FRAC_BITS  = 16;
	localparam int DIFF_BITS  = VALUE_BITS + 1;
	localparam int PROD_BITS  = DIFF_BITS + FRAC_BITS + 1;
	localparam int STEP_BITS  = $clog2(FRAC_BITS);

	localparam logic CMD_LOAD   = 1'b0;
	localparam logic CMD_SAMPLE = 1'b1;

	typedef logic signed [VALUE_BITS-1:0] value_t;

	typedef struct packed {
		value_t x;
		value_t y;
		value_t z;
	} vec3_t;

	localparam int VEC_BITS = $bits(vec3_t);

	typedef enum logic [1:0] {
		COMP_X,
		COMP_Y,
		COMP_Z
	} comp_t;

	function automatic value_t get_comp(vec3_t v, comp_t c);
		value_t r;
		case (c)
			COMP_X:  r = v.x;
			COMP_Y:  r = v.y;
			COMP_Z:  r = v.z;
			default: r = v.x;
		endcase
		return r;
	endfunction

endpackage

### rtl/kvs_ram.sv
// ----------------------------------------------------------------------------
// kvs_ram: keyframe table memory
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module kvs_ram import kvs_pkg::*; #(
	parameter int WIDTH = 16
) (
	input  logic                clk,
	input  logic                we,
	input  logic [KEY_BITS-1:0] waddr,
	input  logic [WIDTH-1:0]    wdata,
	input  logic [KEY_BITS-1:0] raddr,
	output logic [WIDTH-1:0]    rdata
);

	logic [WIDTH-1:0] mem [MAX_KEYS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

### rtl/kvs_div.sv
// ----------------------------------------------------------------------------
// kvs_div: serial fraction divider
// Computes (num << 16) / den for num < den, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module kvs_div import kvs_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [TIME_BITS-1:0] num,
	input  logic [TIME_BITS-1:0] den,
	output logic                 done,
	output logic [FRAC_BITS-1:0] quot
);

	logic                 busy_q;
	logic                 done_q;
	logic [STEP_BITS-1:0] step_q;
	logic [TIME_BITS-1:0] rem_q;
	logic [TIME_BITS-1:0] den_q;
	logic [FRAC_BITS-1:0] quot_q;
	logic [TIME_BITS:0]   rem_dbl;
	logic                 ge;

	// The remainder stays below den, so doubling it needs one extra bit only.
	assign rem_dbl = {rem_q, 1'b0};
	assign ge      = rem_dbl >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= busy_q && !start && (step_q == '0);
			if (start) begin
				busy_q <= 1'b1;
				step_q <= STEP_BITS'(FRAC_BITS - 1);
			end else if (busy_q) begin
				step_q <= step_q - 1'b1;
				if (step_q == '0) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= num;
			den_q  <= den;
			quot_q <= '0;
		end else if (busy_q) begin
			quot_q <= {quot_q[FRAC_BITS-2:0], ge};
			if (ge) begin
				rem_q <= TIME_BITS'(rem_dbl - {1'b0, den_q});
			end else begin
				rem_q <= rem_dbl[TIME_BITS-1:0];
			end
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule

### rtl/kvs_lerp.sv
// ----------------------------------------------------------------------------
// kvs_lerp: shared linear interpolation unit
// Runs x, y and z through one subtract, multiply and add pipeline in turn.
// ----------------------------------------------------------------------------
module kvs_lerp import kvs_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [FRAC_BITS-1:0] frac,
	input  vec3_t                a,
	input  vec3_t                b,
	output logic                 done,
	output vec3_t                res
);

	logic                        active_q;
	comp_t                       cnt_q;
	logic [FRAC_BITS-1:0]        frac_q;
	logic                        v_s1;
	comp_t                       idx_s1;
	logic signed [DIFF_BITS-1:0] d_s1;
	logic                        v_s2;
	comp_t                       idx_s2;
	logic signed [PROD_BITS-1:0] prod_s2;
	logic                        done_q;
	vec3_t                       res_q;
	value_t                      a_sel;
	value_t                      b_sel;
	value_t                      sum;

	assign a_sel = get_comp(a, cnt_q);
	assign b_sel = get_comp(b, cnt_q);
	// Bits above the shift give the floored product, wrapped to the value width.
	assign sum = get_comp(a, idx_s2) + prod_s2[FRAC_BITS +: VALUE_BITS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			cnt_q    <= COMP_X;
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			v_s1   <= active_q;
			v_s2   <= v_s1;
			done_q <= v_s2 && (idx_s2 == COMP_Z);
			if (start) begin
				active_q <= 1'b1;
				cnt_q    <= COMP_X;
			end else if (active_q) begin
				case (cnt_q)
					COMP_X:  cnt_q <= COMP_Y;
					COMP_Y:  cnt_q <= COMP_Z;
					default: active_q <= 1'b0;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			frac_q <= frac;
		end
		idx_s1  <= cnt_q;
		d_s1    <= {b_sel[VALUE_BITS-1], b_sel} - {a_sel[VALUE_BITS-1], a_sel};
		idx_s2  <= idx_s1;
		prod_s2 <= d_s1 * $signed({1'b0, frac_q});
		if (v_s2) begin
			case (idx_s2)
				COMP_X:  res_q.x <= sum;
				COMP_Y:  res_q.y <= sum;
				COMP_Z:  res_q.z <= sum;
				default: res_q.x <= sum;
			endcase
		end
	end

	assign done = done_q;
	assign res  = res_q;

endmodule

### rtl/keyframe_vector_sampler.sv
// ----------------------------------------------------------------------------
// keyframe_vector_sampler: keyframe table with interpolated sampling
// Stores up to 256 xyz keyframes and returns the linearly interpolated value
// at a query time, found by binary search over the time table.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (in_valid/in_stall) carries load and sample items. A load
// writes one keyframe in the cycle of its transfer and yields no result. A
// sample yields one result on the output channel (out_valid/out_stall).
// The key_count register is written over the cfg channel (cfg_valid and
// cfg_ready, always ready); reset sets it to 1. The user must write it only
// while the block is idle; the block itself does not enforce this.
// Items are taken one at a time; in_stall is high while a sample is in work,
// and the next item can transfer in the cycle after its result is loaded.
// A sample clamped at the first key skips the last key check and the search;
// one clamped at the last key skips the search. An interpolated sample passes
// the first and last key checks, up to nine binary search steps and a step to
// close the search, the table reads, the 16-step serial divider if needed,
// the shared multiplier pipeline and the load of the result register.
// The result sits in an output register; a new item is accepted while it waits
// for the receiver, and the next result waits only if that register is full.
// Reset clears control state only; table entries are undefined until loaded.
// ----------------------------------------------------------------------------
module keyframe_vector_sampler import kvs_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  cmd,
	input  logic [KEY_BITS-1:0]   key_index,
	input  logic [TIME_BITS-1:0]  key_time,
	input  logic signed [31:0]    key_x,
	input  logic signed [31:0]    key_y,
	input  logic signed [31:0]    key_z,
	input  logic [TIME_BITS-1:0]  query_time,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic signed [31:0]    out_x,
	output logic signed [31:0]    out_y,
	output logic signed [31:0]    out_z,
	output logic [KEY_BITS-1:0]   lower_key,
	output logic                  clamped,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [COUNT_BITS-1:0] cfg_data
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CHK_FIRST,
		ST_CHK_LAST,
		ST_SRCH_RD,
		ST_SRCH_CMP,
		ST_RD_LO,
		ST_RD_HI,
		ST_CAP_HI,
		ST_FRAC,
		ST_DIV,
		ST_LERP,
		ST_EMIT
	} state_t;

	state_t                state_q;
	logic [COUNT_BITS-1:0] key_count_q;
	logic [COUNT_BITS-1:0] n_q;
	logic [TIME_BITS-1:0]  query_q;
	logic [COUNT_BITS-1:0] begin_q;
	logic [COUNT_BITS-1:0] cnt_q;
	logic [KEY_BITS-1:0]   k0_q;
	logic [KEY_BITS-1:0]   k1_q;
	logic                  clamp_q;
	logic [TIME_BITS-1:0]  from_q;
	logic [TIME_BITS-1:0]  num_q;
	logic [TIME_BITS-1:0]  den_q;
	vec3_t                 a_q;
	vec3_t                 b_q;
	logic                  out_valid_q;
	vec3_t                 out_q;
	logic [KEY_BITS-1:0]   lower_q;
	logic                  clamped_q;

	logic                  in_xfer;
	logic                  mem_we;
	logic [KEY_BITS-1:0]   raddr;
	logic [TIME_BITS-1:0]  t_rdata;
	vec3_t                 v_rdata;
	vec3_t                 v_wdata;
	logic [COUNT_BITS-1:0] n_eff;
	logic [KEY_BITS-1:0]   last_key;
	logic [COUNT_BITS-1:0] half;
	logic [COUNT_BITS-1:0] mid;
	logic [COUNT_BITS-1:0] frame_raw;
	logic [COUNT_BITS-1:0] frame_max;
	logic [COUNT_BITS-1:0] frame;
	logic [TIME_BITS-1:0]  num_c;
	logic [TIME_BITS-1:0]  den_c;
	logic                  frac_zero;
	logic                  frac_sat;
	logic                  div_go;
	logic                  div_done;
	logic [FRAC_BITS-1:0]  div_quot;
	logic                  lerp_go;
	logic [FRAC_BITS-1:0]  lerp_frac;
	logic                  lerp_done;
	vec3_t                 lerp_res;
	logic                  out_free;

	assign in_xfer   = in_valid && !in_stall;
	assign in_stall  = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	assign mem_we    = in_xfer && (cmd == CMD_LOAD);
	assign v_wdata   = '{x: key_x, y: key_y, z: key_z};
	assign out_free  = !out_valid_q || !out_stall;

	// A count of zero behaves as one key; counts past the table size saturate.
	always_comb begin
		if (key_count_q == '0) begin
			n_eff = COUNT_BITS'(1);
		end else if (key_count_q > COUNT_BITS'(MAX_KEYS)) begin
			n_eff = COUNT_BITS'(MAX_KEYS);
		end else begin
			n_eff = key_count_q;
		end
	end

	assign last_key  = KEY_BITS'(n_q - 1'b1);
	assign half      = cnt_q >> 1;
	assign mid       = begin_q + half;
	assign frame_raw = (begin_q == '0) ? '0 : begin_q - 1'b1;
	assign frame_max = n_q - COUNT_BITS'(2);
	assign frame     = (frame_raw > frame_max) ? frame_max : frame_raw;

	assign num_c     = (query_q > from_q) ? query_q - from_q : '0;
	assign den_c     = (t_rdata > from_q) ? t_rdata - from_q : '0;
	assign frac_zero = clamp_q || (num_q == '0) || (den_q == '0);
	assign frac_sat  = (num_q >= den_q);

	always_comb begin
		case (state_q)
			ST_IDLE:      raddr = '0;
			ST_CHK_FIRST: raddr = last_key;
			ST_SRCH_RD:   raddr = mid[KEY_BITS-1:0];
			ST_RD_LO:     raddr = k0_q;
			default:      raddr = k1_q;
		endcase
	end

	assign div_go  = (state_q == ST_FRAC) && !frac_zero && !frac_sat;
	assign lerp_go = ((state_q == ST_FRAC) && (frac_zero || frac_sat))
		|| ((state_q == ST_DIV) && div_done);

	always_comb begin
		if (state_q == ST_DIV) begin
			lerp_frac = div_quot;
		end else if (frac_zero) begin
			lerp_frac = '0;
		end else begin
			lerp_frac = '1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			key_count_q <= COUNT_BITS'(1);
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				key_count_q <= cfg_data;
			end
			if ((state_q == ST_EMIT) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_xfer && (cmd == CMD_SAMPLE)) begin
						n_q     <= n_eff;
						query_q <= query_time;
						state_q <= ST_CHK_FIRST;
					end
				end
				ST_CHK_FIRST: begin
					if (query_q <= t_rdata) begin
						k0_q    <= '0;
						k1_q    <= '0;
						clamp_q <= 1'b1;
						state_q <= ST_RD_LO;
					end else begin
						state_q <= ST_CHK_LAST;
					end
				end
				ST_CHK_LAST: begin
					if (query_q >= t_rdata) begin
						k0_q    <= last_key;
						k1_q    <= last_key;
						clamp_q <= 1'b1;
						state_q <= ST_RD_LO;
					end else begin
						begin_q <= '0;
						cnt_q   <= n_q;
						clamp_q <= 1'b0;
						state_q <= ST_SRCH_RD;
					end
				end
				ST_SRCH_RD: begin
					if (cnt_q == '0) begin
						k0_q    <= frame[KEY_BITS-1:0];
						k1_q    <= KEY_BITS'(frame + 1'b1);
						state_q <= ST_RD_LO;
					end else begin
						state_q <= ST_SRCH_CMP;
					end
				end
				ST_SRCH_CMP: begin
					if (t_rdata < query_q) begin
						begin_q <= mid + 1'b1;
						cnt_q   <= cnt_q - half - 1'b1;
					end else begin
						cnt_q <= half;
					end
					state_q <= ST_SRCH_RD;
				end
				ST_RD_LO: begin
					state_q <= ST_RD_HI;
				end
				ST_RD_HI: begin
					from_q  <= t_rdata;
					a_q     <= v_rdata;
					state_q <= ST_CAP_HI;
				end
				ST_CAP_HI: begin
					b_q     <= v_rdata;
					num_q   <= num_c;
					den_q   <= den_c;
					state_q <= ST_FRAC;
				end
				ST_FRAC: begin
					state_q <= div_go ? ST_DIV : ST_LERP;
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_LERP;
					end
				end
				ST_LERP: begin
					if (lerp_done) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						out_q     <= lerp_res;
						lower_q   <= k0_q;
						clamped_q <= clamp_q;
						state_q   <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	kvs_ram #(.WIDTH(TIME_BITS)) u_time_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (key_index),
		.wdata (key_time),
		.raddr (raddr),
		.rdata (t_rdata)
	);

	kvs_ram #(.WIDTH(VEC_BITS)) u_value_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (key_index),
		.wdata (v_wdata),
		.raddr (raddr),
		.rdata (v_rdata)
	);

	kvs_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_go),
		.num    (num_q),
		.den    (den_q),
		.done   (div_done),
		.quot   (div_quot)
	);

	kvs_lerp u_lerp (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (lerp_go),
		.frac   (lerp_frac),
		.a      (a_q),
		.b      (b_q),
		.done   (lerp_done),
		.res    (lerp_res)
	);

	assign out_valid = out_valid_q;
	assign out_x     = out_q.x;
	assign out_y     = out_q.y;
	assign out_z     = out_q.z;
	assign lower_key = lower_q;
	assign clamped   = clamped_q;

endmodule

### tb/tb_keyframe_vector_sampler.sv
// ----------------------------------------------------------------------------
// tb_keyframe_vector_sampler: self-checking bench for the keyframe sampler
// Loads keyframe tables, programs key_count and samples the channel through
// the valid/stall channels with random idling on both sides. A local
// predictor computes each expected xyz result, lower key and clamp flag, and
// every result transfer is compared with the oldest pending prediction.
// ----------------------------------------------------------------------------
module tb_keyframe_vector_sampler;
	timeunit 1ns;
	timeprecision 1ps;

	import kvs_pkg::*;

	localparam int STALL_LIMIT  = 2000;
	localparam int DRAIN_CYCLES = 64;

	typedef struct packed {
		vec3_t                val;
		logic [KEY_BITS-1:0]  lower;
		logic                 clamped;
	} sample_result_t;

	logic                  clk         = 1'b0;
	logic                  arst_n      = 1'b0;
	logic                  in_valid    = 1'b0;
	logic                  cmd         = CMD_LOAD;
	logic [KEY_BITS-1:0]   key_index   = '0;
	logic [TIME_BITS-1:0]  key_time    = '0;
	value_t                key_x       = '0;
	value_t                key_y       = '0;
	value_t                key_z       = '0;
	logic [TIME_BITS-1:0]  query_time  = '0;
	logic                  out_stall   = 1'b0;
	logic                  cfg_valid   = 1'b0;
	logic [COUNT_BITS-1:0] cfg_data    = '0;
	logic                  in_stall;
	logic                  out_valid;
	value_t                out_x;
	value_t                out_y;
	value_t                out_z;
	logic [KEY_BITS-1:0]   lower_key;
	logic                  clamped;
	logic                  cfg_ready;

	// Local copy of the channel table and the key_count register.
	logic [TIME_BITS-1:0]  key_times [MAX_KEYS];
	vec3_t                 key_vals [MAX_KEYS];
	logic [COUNT_BITS-1:0] key_count_reg = COUNT_BITS'(1);

	sample_result_t        pending_samples [$];
	int unsigned           items_sent     = 0;
	int unsigned           mismatch_count = 0;
	int unsigned           quiet_cycles   = 0;
	bit                    steady_run     = 1'b0;

	keyframe_vector_sampler uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.cmd        (cmd),
		.key_index  (key_index),
		.key_time   (key_time),
		.key_x      (key_x),
		.key_y      (key_y),
		.key_z      (key_z),
		.query_time (query_time),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_x      (out_x),
		.out_y      (out_y),
		.out_z      (out_z),
		.lower_key  (lower_key),
		.clamped    (clamped),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------------
	function automatic int unsigned active_keys();
		int unsigned n;
		n = 32'(key_count_reg);
		if (n == 0)
			n = 1;
		if (n > MAX_KEYS)
			n = MAX_KEYS;
		return n;
	endfunction

	// a + floor((b - a) * frac / 2^16); the product fits easily in 64 bits.
	function automatic value_t blend(value_t a, value_t b, int unsigned frac);
		longint d;
		longint p;
		d = longint'(b) - longint'(a);
		p = d * longint'(frac);
		return value_t'(longint'(a) + (p >>> FRAC_BITS));
	endfunction

	function automatic sample_result_t make_result(int unsigned k0, int unsigned k1,
			int unsigned frac, int unsigned lower, logic clamp);
		sample_result_t r;
		r.val.x   = blend(key_vals[k0].x, key_vals[k1].x, frac);
		r.val.y   = blend(key_vals[k0].y, key_vals[k1].y, frac);
		r.val.z   = blend(key_vals[k0].z, key_vals[k1].z, frac);
		r.lower   = KEY_BITS'(lower);
		r.clamped = clamp;
		return r;
	endfunction

	function automatic sample_result_t predict_sample(logic [TIME_BITS-1:0] q);
		int unsigned n, first, cnt, half, mid, frame, from, to, num, den, frac, qv;
		n  = active_keys();
		qv = 32'(q);
		if (q <= key_times[0])
			return make_result(0, 0, 0, 0, 1'b1);
		if (q >= key_times[n-1])
			return make_result(n - 1, n - 1, 0, n - 1, 1'b1);
		// Lower bound search: first key whose time is not below the query.
		first = 0;
		cnt   = n;
		while (cnt != 0) begin
			half = cnt >> 1;
			mid  = first + half;
			if (key_times[mid] < q) begin
				first = mid + 1;
				cnt   = cnt - half - 1;
			end else begin
				cnt = half;
			end
		end
		frame = (first == 0) ? 0 : first - 1;
		if (frame > n - 2)
			frame = n - 2;
		from = 32'(key_times[frame]);
		to   = 32'(key_times[frame+1]);
		num  = (qv > from) ? qv - from : 0;
		den  = (to > from) ? to - from : 0;
		if (den == 0 || num == 0)
			frac = 0;
		else if (num >= den)
			frac = 32'hFFFF;
		else
			frac = (num << FRAC_BITS) / den;
		return make_result(frame, frame + 1, frac, frame, 1'b0);
	endfunction

	// ------------------------------------------------------------------------
	// Result checking
	// ------------------------------------------------------------------------
	task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("MISMATCH %s: expected %h, got %h at %0t", what, want, got, $realtime);
	endtask

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got)
			report_mismatch(name, want, got);
	endtask

	always @(posedge clk) begin
		sample_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_samples.size() == 0) begin
				report_mismatch("result with no sample pending", '0, out_x);
			end else begin
				want = pending_samples.pop_front();
				check_field("out_x", want.val.x, out_x);
				check_field("out_y", want.val.y, out_y);
				check_field("out_z", want.val.z, out_z);
				check_field("lower_key", 32'(want.lower), 32'(lower_key));
				check_field("clamped", 32'(want.clamped), 32'(clamped));
			end
		end
	end

	always @(posedge clk)
		out_stall <= !steady_run && ($urandom_range(99) < 6);

	// Ends the run if no transfer of any kind happens for too long.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
				|| (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles == STALL_LIMIT) begin
				$display("Mismatches found");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------------
	function automatic value_t pick_value();
		case ($urandom_range(15))
			0:       return value_t'(32'h8000_0000);
			1:       return value_t'(32'h7FFF_FFFF);
			2:       return value_t'(32'h0000_0000);
			3:       return value_t'(32'hFFFF_FFFF);
			default: return value_t'($urandom);
		endcase
	endfunction

	function automatic vec3_t pick_vec();
		vec3_t v;
		v.x = pick_value();
		v.y = pick_value();
		v.z = pick_value();
		return v;
	endfunction

	// Valid stays high from one transfer to the next unless an idle cycle is drawn.
	task automatic send_item(logic op, logic [KEY_BITS-1:0] idx, logic [TIME_BITS-1:0] kt,
			vec3_t v, logic [TIME_BITS-1:0] qt);
		if (!steady_run) begin
			while ($urandom_range(99) < 6) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
		end
		in_valid   <= 1'b1;
		cmd        <= op;
		key_index  <= idx;
		key_time   <= kt;
		key_x      <= v.x;
		key_y      <= v.y;
		key_z      <= v.z;
		query_time <= qt;
		do
			@(posedge clk);
		while (in_stall);
		items_sent++;
		if (op == CMD_LOAD) begin
			key_times[idx] = kt;
			key_vals[idx]  = v;
		end else begin
			pending_samples.push_back(predict_sample(qt));
		end
	endtask

	task automatic load_key(logic [KEY_BITS-1:0] idx, logic [TIME_BITS-1:0] t, vec3_t v);
		send_item(CMD_LOAD, idx, t, v, TIME_BITS'($urandom));
	endtask

	task automatic sample_at(logic [TIME_BITS-1:0] t);
		send_item(CMD_SAMPLE, KEY_BITS'($urandom), TIME_BITS'($urandom), pick_vec(), t);
	endtask

	// Stops sending and waits until every pending result is in.
	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_samples.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_key_count(logic [COUNT_BITS-1:0] value);
		drain_results();
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid     <= 1'b0;
		key_count_reg  = value;
	endtask

	// Sorted tables have strictly increasing times; the others are crowded
	// into a narrow window so that order breaks and times repeat.
	task automatic build_table(int unsigned n, bit sorted);
		int unsigned t, base, step_max;
		base     = $urandom_range(2000);
		t        = base;
		step_max = (65535 - 2000) / n;
		if ($urandom_range(3) == 0)
			step_max = 3;
		for (int unsigned i = 0; i < n; i++) begin
			load_key(KEY_BITS'(i),
				TIME_BITS'(sorted ? t : base + $urandom_range(200)), pick_vec());
			t += $urandom_range(step_max, 1);
		end
	endtask

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------
	task automatic test_reset_count();
		// key_count is 1 out of reset, so only entry 0 is read.
		load_key(0, 16'h4000, '{32'h1234_5678, 32'h8000_0000, 32'h7FFF_FFFF});
		sample_at(16'h0000);
		sample_at(16'h4000);
		sample_at(16'hFFFF);
	endtask

	task automatic test_count_limits();
		build_table(MAX_KEYS, 1'b1);
		set_key_count(0);
		sample_at(16'h0000);
		sample_at(16'hFFFF);
		set_key_count(511);
		sample_at(16'hFFFF);
		sample_at(TIME_BITS'(key_times[100] + 1));
		set_key_count(256);
		sample_at(key_times[255]);
		sample_at(TIME_BITS'(key_times[255] - 1));
		sample_at(key_times[128]);
		set_key_count(257);
		sample_at(16'h8000);
	endtask

	task automatic test_interp_edges();
		load_key(0, 16'h0010, '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000});
		load_key(1, 16'h8000, '{32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF});
		load_key(2, 16'h8001, '{32'h0000_0000, 32'h0000_0001, 32'h1234_5678});
		load_key(3, 16'hFFFE, '{32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF});
		set_key_count(4);
		sample_at(16'h0000);
		sample_at(16'h0010);
		sample_at(16'h0011);
		sample_at(16'h7FFF);
		sample_at(16'h8000);
		sample_at(16'h8001);
		sample_at(16'hFFFD);
		sample_at(16'hFFFE);
		sample_at(16'hFFFF);
		// Key 1 moved past key 2 leaves the table out of order.
		load_key(1, 16'hC000, '{32'h0001_0000, 32'hFFFF_0000, 32'h8000_0001});
		sample_at(16'h9000);
		sample_at(16'h4000);
	endtask

	task automatic test_random(int unsigned target, bit no_idle);
		int unsigned n, pick, lo, hi;
		logic [COUNT_BITS-1:0] setting;
		steady_run = no_idle;
		while (items_sent < target) begin
			pick = $urandom_range(99);
			if (pick < 5)
				setting = COUNT_BITS'($urandom_range(511, 257));
			else if (pick < 12)
				setting = COUNT_BITS'($urandom_range(256, 17));
			else if (pick < 18)
				setting = COUNT_BITS'($urandom_range(1, 0));
			else
				setting = COUNT_BITS'($urandom_range(16, 2));
			set_key_count(setting);
			n = active_keys();
			if ($urandom_range(3) < ((n > 16) ? 1 : 3))
				build_table(n, $urandom_range(4) != 0);
			repeat ($urandom_range(24, 8)) begin
				pick = $urandom_range(99);
				lo   = 32'(key_times[0]);
				hi   = 32'(key_times[n-1]);
				if (pick < 8)
					load_key(KEY_BITS'($urandom), TIME_BITS'($urandom), pick_vec());
				else if (pick < 22)
					sample_at(TIME_BITS'(key_times[$urandom_range(n - 1)]
						+ $urandom_range(2) - 1));
				else if (pick < 32 || hi <= lo)
					sample_at(TIME_BITS'($urandom));
				else
					sample_at(TIME_BITS'($urandom_range(hi, lo)));
			end
		end
		steady_run = 1'b0;
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_count();
		test_count_limits();
		test_interp_edges();
		test_random(items_sent + 300, 1'b0);
		test_random(items_sent + 200, 1'b1);
		test_random(items_sent + 300, 1'b0);
		drain_results();
		if (mismatch_count == 0 && pending_samples.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

### sim.f
rtl/kvs_pkg.sv
rtl/kvs_ram.sv
rtl/kvs_div.sv
rtl/kvs_lerp.sv
rtl/keyframe_vector_sampler.sv
tb/tb_keyframe_vector_sampler.sv
